### rtl/prrs_pkg.sv
// Shared types and operation codes for the priority round-robin scheduler.
`timescale 1ns / 1ps

package prrs_pkg;

   // Operation codes carried on the request tuser.
   localparam logic [1:0] OP_ADD       = 2'd0;
   localparam logic [1:0] OP_YIELD     = 2'd1;
   localparam logic [1:0] OP_TERMINATE = 2'd2;
   localparam logic [1:0] OP_PEEK      = 2'd3;

   // Widths of the request and response fields.
   localparam int unsigned OP_W       = 2;
   localparam int unsigned TASK_W     = 6;
   localparam int unsigned LEVEL_W    = 4;
   localparam int unsigned REQ_W      = 16;
   localparam int unsigned RSP_W      = 8;
   localparam int unsigned RSP_USER_W = 2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LEVEL,
      ST_POP,
      ST_RESULT
   } state_type;

endpackage

### rtl/priority_round_robin_scheduler_top.sv
// Multilevel priority round-robin ready queue with one FIFO list per level.
`timescale 1ns / 1ps

//  Channel | Direction | Fields (lowest bit first)                              | Widths
//  --------+-----------+--------------------------------------------------------+-------
//  req_    | in        | tdata: task_id[5:0], level[9:6], zeros; tuser: op[1:0] | 16, 2
//  rsp_    | out       | tdata: next_task[5:0], zeros; tuser: none_ready, status | 8, 2
//
//  An add or peek, and a yield or terminate without a current task, go from
//  the idle state straight to the result state, which loads the result
//  register and returns to idle; requests are taken only in the idle state. A
//  yield or terminate with a current task first reads the task's level from
//  memory in the level state; if that level holds one task, or none, the
//  result state follows. Rotating or removing the head of a longer list adds
//  the pop state, which reads the link memory and moves the head; a yield also
//  writes the link memory there to append the old head. The result register lets a new
//  request be taken while the previous result still waits; a result is held
//  back only while that register is still occupied. Reset is synchronous and
//  has no clearing pass for the link and level memories: the user must see that
//  they are only read at entries that were written; the block does not enforce it.

module priority_round_robin_scheduler_top #(
   parameter int unsigned MAX_TASKS  = 64,
   parameter int unsigned NUM_LEVELS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: task_id[5:0], level[9:6], zero fill[15:10]
   input  logic [prrs_pkg::REQ_W-1:0]      req_tdata,
   // req_tuser: op[1:0]
   input  logic [prrs_pkg::OP_W-1:0]       req_tuser,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // rsp_tdata: next_task[5:0], zero fill[7:6]
   output logic [prrs_pkg::RSP_W-1:0]      rsp_tdata,
   // rsp_tuser: none_ready[0], status[1]
   output logic [prrs_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready
);

   import prrs_pkg::*;

   localparam int unsigned TW = (MAX_TASKS  > 1) ? $clog2(MAX_TASKS)  : 1;
   localparam int unsigned LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

   // Request fields.
   logic [OP_W-1:0]    req_op;
   logic [TASK_W-1:0]  req_task_id;
   logic [LEVEL_W-1:0] req_level;
   logic               req_in_range;
   logic               req_xfer;

   assign req_op       = req_tuser;
   assign req_task_id  = req_tdata[5:0];
   assign req_level    = req_tdata[9:6];
   assign req_in_range = (32'(req_task_id) < MAX_TASKS) && (32'(req_level) < NUM_LEVELS);
   assign req_xfer     = req_tvalid && req_tready;

   // The link and level stores are synchronous memories with registered reads.
   logic [TW-1:0] link_next_ff  [MAX_TASKS];
   logic [LW-1:0] task_level_ff [MAX_TASKS];
   logic [TW-1:0] link_rd_ff;
   logic [LW-1:0] level_rd_ff;

   // Per-level list heads and tails, and the nonempty bitmap.
   logic [TW-1:0]         head_ff [NUM_LEVELS];
   logic [TW-1:0]         tail_ff [NUM_LEVELS];
   logic [NUM_LEVELS-1:0] nonempty_ff, nonempty_in;

   // Control and per-operation registers.
   state_type       state_ff, state_in;
   logic [OP_W-1:0] op_ff, op_in;
   logic            status_ff, status_in;
   logic [LW-1:0]   cl_ff, cl_in;
   logic [TW-1:0]   pop_ff, pop_in;
   logic [TW-1:0]   cur_task_ff, cur_task_in;
   logic            cur_valid_ff, cur_valid_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   // Write ports of the memories and the head and tail arrays.
   logic          link_we;
   logic [TW-1:0] link_wa, link_wd, link_ra;
   logic          level_we;
   logic [TW-1:0] level_wa;
   logic [LW-1:0] level_wd;
   logic          head_we, tail_we;
   logic [LW-1:0] head_wa, tail_wa;
   logic [TW-1:0] head_wd, tail_wd;

   // One shared read of the head and tail arrays and the bitmap, at rd_lvl.
   logic [LW-1:0] rd_lvl;
   logic [TW-1:0] rd_head, rd_tail;
   logic          rd_ne;

   // Lowest nonempty level.
   logic [LW-1:0] best_lvl;
   logic          any_ready;
   logic          out_free;
   logic          single;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign any_ready = |nonempty_ff;
   assign single    = (rd_head == rd_tail);

   always_comb begin
      best_lvl = '0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (nonempty_ff[i]) begin
            best_lvl = LW'(i);
         end
      end
   end

   always_comb begin
      unique case (state_ff)
         ST_IDLE:   rd_lvl = LW'(req_level);
         ST_LEVEL:  rd_lvl = level_rd_ff;
         ST_POP:    rd_lvl = cl_ff;
         ST_RESULT: rd_lvl = best_lvl;
         default:   rd_lvl = '0;
      endcase
   end

   assign rd_head = head_ff[rd_lvl];
   assign rd_tail = tail_ff[rd_lvl];
   assign rd_ne   = nonempty_ff[rd_lvl];
   assign link_ra = rd_head;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if ((req_op == OP_YIELD || req_op == OP_TERMINATE) && cur_valid_ff) begin
                  state_in = ST_LEVEL;
               end else begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_LEVEL: begin
            if (rd_ne && !single) begin
               state_in = ST_POP;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_POP: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // List updates, result and current task.
   always_comb begin
      op_in        = op_ff;
      status_in    = status_ff;
      cl_in        = cl_ff;
      pop_in       = pop_ff;
      cur_task_in  = cur_task_ff;
      cur_valid_in = cur_valid_ff;
      nonempty_in  = nonempty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      link_we      = 1'b0;
      link_wa      = rd_tail;
      link_wd      = pop_ff;
      level_we     = 1'b0;
      level_wa     = TW'(req_task_id);
      level_wd     = LW'(req_level);
      head_we      = 1'b0;
      head_wa      = rd_lvl;
      head_wd      = TW'(req_task_id);
      tail_we      = 1'b0;
      tail_wa      = rd_lvl;
      tail_wd      = TW'(req_task_id);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               op_in     = req_op;
               status_in = 1'b0;
               if (req_op == OP_ADD && req_in_range) begin
                  // Append at the tail of the level, or start a new list.
                  level_we = 1'b1;
                  tail_we  = 1'b1;
                  if (rd_ne) begin
                     link_we = 1'b1;
                     link_wd = TW'(req_task_id);
                  end else begin
                     head_we             = 1'b1;
                     nonempty_in[rd_lvl] = 1'b1;
                  end
               end else if ((req_op == OP_YIELD || req_op == OP_TERMINATE) && !cur_valid_ff) begin
                  status_in = 1'b1;
               end
            end
         end
         ST_LEVEL: begin
            // The level of the current task has arrived from memory.
            cl_in  = level_rd_ff;
            pop_in = rd_head;
            if (rd_ne && single && op_ff == OP_TERMINATE) begin
               nonempty_in[rd_lvl] = 1'b0;
            end
         end
         ST_POP: begin
            // Unlink the head; a yield then appends it behind the old tail.
            head_we = 1'b1;
            head_wd = link_rd_ff;
            if (op_ff == OP_YIELD) begin
               link_we = 1'b1;
               tail_we = 1'b1;
               tail_wd = pop_ff;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_W - TASK_W){1'b0}},
                               any_ready ? TASK_W'(rd_head) : TASK_W'(0)};
               rsp_user_in  = {status_ff, !any_ready};
               if (op_ff == OP_PEEK ||
                   ((op_ff == OP_YIELD || op_ff == OP_TERMINATE) && !status_ff)) begin
                  cur_valid_in = any_ready;
                  cur_task_in  = any_ready ? rd_head : '0;
               end
            end
         end
         default: ;
      endcase
   end

   // Memories: one write and one registered read each per cycle.
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_next_ff[link_wa] <= link_wd;
      end
      link_rd_ff <= link_next_ff[link_ra];
   end

   always_ff @(posedge clock) begin
      if (level_we) begin
         task_level_ff[level_wa] <= level_wd;
      end
      level_rd_ff <= task_level_ff[cur_task_ff];
   end

   // Head and tail arrays, cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else begin
         if (head_we) begin
            head_ff[head_wa] <= head_wd;
         end
         if (tail_we) begin
            tail_ff[tail_wa] <= tail_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nonempty_ff  <= '0;
         cur_task_ff  <= '0;
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nonempty_ff  <= nonempty_in;
         cur_task_ff  <= cur_task_in;
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      status_ff   <= status_in;
      cl_ff       <= cl_in;
      pop_ff      <= pop_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

### bench/tb_priority_round_robin_scheduler_top.sv
// Self-checking testbench for the priority round-robin scheduler, directed and random operations.
`timescale 1ns / 1ps

module tb_priority_round_robin_scheduler_top;
   import prrs_pkg::*;

   localparam int TASKS         = 64;
   localparam int LEVELS        = 16;
   localparam int RANDOM_OPS    = 900;
   localparam int NOISE_OPS     = 150;
   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 12;
   localparam int FILL_W        = REQ_W - TASK_W - LEVEL_W;

   // One response transfer: rsp_tuser above the task number from rsp_tdata.
   typedef struct packed {
      logic              status;
      logic              none_ready;
      logic [TASK_W-1:0] next_task;
   } sched_result_type;

   // Keeps a private copy of the ready queue, works out the response that each
   // accepted request must produce, and compares the responses in order.
   class ready_queue_scoreboard;
      logic [TASK_W-1:0]  succ     [TASKS];
      logic [LEVEL_W-1:0] task_lvl [TASKS];
      bit                 succ_set [TASKS];
      bit                 lvl_set  [TASKS];
      int                 queued   [TASKS];
      logic [TASK_W-1:0]  lvl_head [LEVELS];
      logic [TASK_W-1:0]  lvl_tail [LEVELS];
      logic [LEVELS-1:0]  lvl_busy;
      logic [TASK_W-1:0]  cur_task;
      bit                 cur_valid;
      sched_result_type   pending_results [$];
      int                 errors;

      function new();
         for (int i = 0; i < TASKS; i++) begin
            succ[i]     = '0;
            task_lvl[i] = '0;
            succ_set[i] = 1'b0;
            lvl_set[i]  = 1'b0;
            queued[i]   = 0;
         end
         for (int i = 0; i < LEVELS; i++) begin
            lvl_head[i] = '0;
            lvl_tail[i] = '0;
         end
         lvl_busy  = '0;
         cur_task  = '0;
         cur_valid = 1'b0;
         errors    = 0;
      endfunction

      function void append(logic [TASK_W-1:0] t, logic [LEVEL_W-1:0] lv);
         if (lvl_busy[lv]) begin
            succ[lvl_tail[lv]]     = t;
            succ_set[lvl_tail[lv]] = 1'b1;
         end else begin
            lvl_head[lv] = t;
            lvl_busy[lv] = 1'b1;
         end
         lvl_tail[lv] = t;
      endfunction

      function logic [TASK_W-1:0] pop_head(logic [LEVEL_W-1:0] lv);
         logic [TASK_W-1:0] h;
         h = lvl_head[lv];
         if (h == lvl_tail[lv]) lvl_busy[lv] = 1'b0;
         else lvl_head[lv] = succ[h];
         return h;
      endfunction

      // True when the operation would make the block read a link or level
      // entry that has never been written.
      function bit reads_blank(logic [1:0] op);
         logic [LEVEL_W-1:0] cl;
         if (!(op == OP_YIELD || op == OP_TERMINATE) || !cur_valid) return 1'b0;
         if (!lvl_set[cur_task]) return 1'b1;
         cl = task_lvl[cur_task];
         return lvl_busy[cl] && (lvl_head[cl] != lvl_tail[cl]) && !succ_set[lvl_head[cl]];
      endfunction

      function int queued_count();
         int n;
         n = 0;
         for (int i = 0; i < TASKS; i++) if (queued[i] > 0) n++;
         return n;
      endfunction

      function bit find_idle_task(output logic [TASK_W-1:0] t);
         for (int i = 0; i < 16; i++) begin
            t = TASK_W'($urandom_range(0, TASKS - 1));
            if (queued[t] == 0) return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_request(logic [1:0] op, logic [TASK_W-1:0] tid,
                                 logic [LEVEL_W-1:0] lv);
         sched_result_type   exp;
         logic [LEVEL_W-1:0] cl;
         logic [TASK_W-1:0]  h;
         int                 best;
         bit                 fault;
         fault = 1'b0;
         best  = -1;
         case (op) inside
            OP_ADD: begin
               task_lvl[tid] = lv;
               lvl_set[tid]  = 1'b1;
               queued[tid]++;
               append(tid, lv);
            end
            OP_YIELD, OP_TERMINATE: begin
               if (!cur_valid) begin
                  fault = 1'b1;
               end else begin
                  cl = task_lvl[cur_task];
                  // A current task whose level has run dry changes no list.
                  if (lvl_busy[cl]) begin
                     h = pop_head(cl);
                     if (op == OP_YIELD) append(h, cl);
                     else if (queued[h] > 0) queued[h]--;
                  end
               end
            end
            default: ;
         endcase
         for (int i = LEVELS - 1; i >= 0; i--) if (lvl_busy[i]) best = i;
         exp.status     = fault;
         exp.none_ready = (best < 0);
         exp.next_task  = (best < 0) ? '0 : lvl_head[best];
         if (op == OP_PEEK || ((op == OP_YIELD || op == OP_TERMINATE) && !fault)) begin
            cur_valid = (best >= 0);
            cur_task  = exp.next_task;
         end
         pending_results.push_back(exp);
      endfunction

      function void check_result(logic [RSP_W-1:0] data, logic [RSP_USER_W-1:0] user);
         sched_result_type got, exp;
         got = {user, data[TASK_W-1:0]};
         if (pending_results.size() == 0) begin
            $display("%0t: response %h/%h arrived with nothing outstanding", $time, user,
                     data);
            errors++;
            return;
         end
         exp = pending_results.pop_front();
         if (got.next_task !== exp.next_task) begin
            $display("%0t: next_task expected %0d, got %0d", $time, exp.next_task,
                     got.next_task);
            errors++;
         end
         if (got.none_ready !== exp.none_ready) begin
            $display("%0t: none_ready expected %0b, got %0b", $time, exp.none_ready,
                     got.none_ready);
            errors++;
         end
         if (got.status !== exp.status) begin
            $display("%0t: status expected %0b, got %0b", $time, exp.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_W-1:0]      req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_W-1:0]      rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;

   ready_queue_scoreboard sb = new();

   int items_sent   = 0;
   bit send_quiet   = 1'b0;
   int results_seen = 0;
   bit rsp_quiet    = 1'b0;
   int rsp_hold     = 0;
   int lvl_lo       = 0;
   int lvl_hi       = LEVELS - 1;

   priority_round_robin_scheduler_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always #1 clock = ~clock;

   // Response side: after each transfer the sink holds tready low for a
   // random number of cycles, except during quiet stretches.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata, rsp_tuser);
         results_seen++;
         if (results_seen % 40 == 0) rsp_quiet = ($urandom_range(0, 3) == 0);
         rsp_hold = rsp_quiet ? 0 : $urandom_range(0, 15);
      end
   end

   // Ends the run when neither channel has seen a transfer for too long.
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle = 0;
         else idle++;
      end
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   // Sends one request after a random gap. An operation that would read a
   // never-written entry is turned into a peek before it is driven.
   task automatic send_op(input logic [1:0] op, input logic [TASK_W-1:0] tid,
                          input logic [LEVEL_W-1:0] lv);
      int         gap;
      logic [1:0] sent_op;
      sent_op = sb.reads_blank(op) ? OP_PEEK : op;
      gap     = send_quiet ? 0 : $urandom_range(0, 15);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {{FILL_W{1'b0}}, lv, tid};
      req_tuser  <= sent_op;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(sent_op, tid, lv);
      items_sent++;
      if (items_sent % 40 == 0) send_quiet = ($urandom_range(0, 3) == 0);
   endtask

   task automatic pause_until_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   // Terminates heads until every level is empty, or for at most 100 requests,
   // peeking first whenever there is no current task.
   task automatic empty_all_levels();
      int tries;
      tries = 0;
      while (sb.lvl_busy != '0 && tries < 100) begin
         send_op(sb.cur_valid ? OP_TERMINATE : OP_PEEK,
                 TASK_W'($urandom_range(0, TASKS - 1)),
                 LEVEL_W'($urandom_range(0, LEVELS - 1)));
         tries++;
      end
   endtask

   task automatic run_directed();
      // Empty queue: peek, yield and terminate with nothing ready and no
      // current task; the ignored fields sit at their extremes.
      send_op(OP_PEEK,      6'd0,  4'd0);
      send_op(OP_YIELD,     6'd63, 4'd15);
      send_op(OP_TERMINATE, 6'd0,  4'd0);
      send_op(OP_ADD,       6'd0,  4'd0);
      send_op(OP_ADD,       6'd5,  4'd0);
      send_op(OP_ADD,       6'd63, 4'd15);
      // Adds leave no current task, so this yield still reports an error.
      send_op(OP_YIELD,     6'd21, 4'd9);
      send_op(OP_PEEK,      6'd42, 4'd6);
      send_op(OP_YIELD,     6'd0,  4'd0);
      send_op(OP_TERMINATE, 6'd0,  4'd0);
      // Duplicate add: task 63 also joins level 7 and takes that level.
      send_op(OP_ADD,       6'd63, 4'd7);
      send_op(OP_TERMINATE, 6'd0,  4'd0);
      send_op(OP_TERMINATE, 6'd0,  4'd0);
      // The current task's level is now empty: no list may change.
      send_op(OP_YIELD,     6'd0,  4'd0);
      send_op(OP_TERMINATE, 6'd0,  4'd0);
      // Re-adding 63 to level 15 closes its list so that it can be removed.
      send_op(OP_ADD,       6'd63, 4'd15);
      send_op(OP_TERMINATE, 6'd0,  4'd0);
      send_op(OP_YIELD,     6'd0,  4'd0);
      send_op(OP_ADD,       6'd42, 4'd3);
      send_op(OP_ADD,       6'd17, 4'd3);
      send_op(OP_ADD,       6'd9,  4'd1);
      send_op(OP_PEEK,      6'd0,  4'd0);
   endtask

   // Mostly well-formed traffic: fresh tasks are added, and the op mix keeps
   // the queue between empty and about forty tasks. The final stretch mixes
   // in arbitrary requests, duplicate adds among them.
   task automatic run_random();
      int                 n;
      int                 r;
      bit                 found;
      logic [1:0]         op;
      logic [TASK_W-1:0]  tid;
      logic [LEVEL_W-1:0] lv;
      for (int k = 0; k < RANDOM_OPS; k++) begin
         if (k % 64 == 0) begin
            if ($urandom_range(0, 1) == 0) begin
               lvl_lo = 0;
               lvl_hi = LEVELS - 1;
            end else begin
               lvl_lo = $urandom_range(0, LEVELS - 1);
               lvl_hi = (lvl_lo + 3 > LEVELS - 1) ? LEVELS - 1 : lvl_lo + 3;
            end
         end
         if (k == 300 || k == 600) begin
            empty_all_levels();
            pause_until_drained();
         end
         lv  = LEVEL_W'($urandom_range(lvl_lo, lvl_hi));
         tid = TASK_W'($urandom_range(0, TASKS - 1));
         r   = $urandom_range(0, 99);
         if (k >= RANDOM_OPS - NOISE_OPS && r < 15) begin
            op  = OP_W'($urandom_range(0, 3));
            lv  = LEVEL_W'($urandom_range(0, LEVELS - 1));
         end else begin
            n = sb.queued_count();
            r = $urandom_range(0, 99);
            if (n < 4)
               op = (r < 60) ? OP_ADD : (r < 75) ? OP_YIELD : (r < 90) ? OP_TERMINATE : OP_PEEK;
            else if (n > 40)
               op = (r < 15) ? OP_ADD : (r < 40) ? OP_YIELD : (r < 90) ? OP_TERMINATE : OP_PEEK;
            else
               op = (r < 35) ? OP_ADD : (r < 65) ? OP_YIELD : (r < 90) ? OP_TERMINATE : OP_PEEK;
            if (op == OP_ADD) begin
               found = sb.find_idle_task(tid);
               if (!found) op = OP_YIELD;
            end
         end
         send_op(op, tid, lv);
      end
   endtask

   initial begin : stimulus
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      pause_until_drained();
      run_random();
      empty_all_levels();
      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
